// ===== design/lxrg_pkg.sv =====
// Package for the lagged-XOR random generator.
// Holds operation codes, fixed field widths and the divider request/response types.
// No dependencies.
package lxrg_pkg;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int SPOS_W = 7;
    localparam int CNT_W  = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WORD    = 3'd0;
    localparam logic [OP_W-1:0] OP_BOUNDED = 3'd1;
    localparam logic [OP_W-1:0] OP_BIT     = 3'd2;
    localparam logic [OP_W-1:0] OP_QUINT   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEED    = 3'd4;
    localparam logic [OP_W-1:0] OP_SETPOS  = 3'd5;

    // Bit and five-bit buffer bookkeeping
    localparam logic [CNT_W-1:0] CNT_FULL   = 6'd32;
    localparam logic [CNT_W-1:0] BIT_STEP   = 6'd1;
    localparam logic [CNT_W-1:0] QUINT_STEP = 6'd5;
    localparam int               QUINT_W    = 5;

    // Divider request, launched by the sequencer
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W:0]   divisor;
    } t_div_req;

    // Divider response
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ===== design/lxrg_if.sv =====
// Valid/ready channel interfaces for the lagged-XOR random generator.
// Depends on lxrg_pkg for field widths.
interface lxrg_in_if;
    import lxrg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic [SPOS_W-1:0]        seed_pos;
    logic [DATA_W-1:0]        seed_word;

    modport source (output valid, op, lo, hi, seed_pos, seed_word, input ready);
    modport sink   (input valid, op, lo, hi, seed_pos, seed_word, output ready);
endinterface

interface lxrg_out_if;
    import lxrg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [DATA_W-1:0]        word;
    logic signed [DATA_W-1:0] bounded_value;
    logic                     range_error;

    modport source (output valid, word, bounded_value, range_error, input ready);
    modport sink   (input valid, word, bounded_value, range_error, output ready);
endinterface

// ===== design/lxrg_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle, remainder only.
// Depends on lxrg_pkg for t_div_req / t_div_rsp.
module lxrg_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lxrg_pkg::t_div_req i_req,
    output lxrg_pkg::t_div_rsp o_rsp
);
    import lxrg_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [DATA_W-1:0] r_dvd, n_dvd;
    logic [DATA_W:0]   r_dvs, n_dvs;
    logic [DATA_W:0]   shifted;

    // One shift-compare-subtract step
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        shifted = {r_rem[DATA_W-1:0], r_dvd[DATA_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = (shifted >= r_dvs) ? (shifted - r_dvs) : shifted;
            n_dvd  = {r_dvd[DATA_W-2:0], 1'b0};
            n_step = r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[DATA_W-1:0];

endmodule

// ===== design/lxrg_table.sv =====
// Feedback table memory: one write port, one registered read port.
// Depends on lxrg_pkg for the data width.
module lxrg_table #(
    parameter int DEPTH = 98,
    parameter int AW    = 7
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lxrg_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lxrg_pkg::DATA_W-1:0] o_rdata
);
    import lxrg_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Contents are undefined until seeded
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lagged_xor_random_generator.sv =====
// Lagged-XOR random generator top level: sequencer, table memory and divider.
// Each input beat is decoded; a bit/five-bit beat served from its buffer or a reversed range goes
// straight to emit, a table draw passes the tap read and XOR states, a bounded draw then waits on the divider.
// Seed/position/unused ops return to idle with no result; a new beat is taken only in idle, and
// a stalled result holds the sequencer in its emit state.
// Reset (synchronous, active low) clears position, buffers and counts; table is not cleared.
module lagged_xor_random_generator #(
    parameter int TABLE_DEPTH = 98,
    parameter int TAP_OFFSET  = 27
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lxrg_in_if.sink   i_in,
    lxrg_out_if.source o_out
);
    import lxrg_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = (AW > SPOS_W) ? AW : SPOS_W;
    localparam int TW = PW + 2;
    localparam logic [PW:0]   LAST_POS = (PW + 1)'(TABLE_DEPTH - 1);
    localparam logic [TW-1:0] DEPTH_T  = TW'(TABLE_DEPTH);
    localparam logic [TW-1:0] TAP_T    = TW'(TAP_OFFSET);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD_TAP = 3'd2;
    localparam logic [2:0] S_XOR    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_lo, r_hi;
    logic [SPOS_W-1:0]        r_seed_pos;
    logic [DATA_W-1:0]        r_seed_word;
    logic [PW-1:0]            r_pos, n_pos;
    logic [AW-1:0]            r_tap, n_tap;
    logic [DATA_W-1:0]        r_a, n_a;
    logic [DATA_W:0]          r_span, n_span;
    logic [DATA_W-1:0]        r_res_word, n_res_word;
    logic [DATA_W-1:0]        r_res_bounded, n_res_bounded;
    logic                     r_res_err, n_res_err;
    logic [DATA_W-1:0]        r_bit_buf, n_bit_buf;
    logic [CNT_W-1:0]         r_bit_cnt, n_bit_cnt;
    logic [DATA_W-1:0]        r_q_buf, n_q_buf;
    logic [CNT_W-1:0]         r_q_cnt, n_q_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [DATA_W-1:0]        r_out_word, n_out_word;
    logic [DATA_W-1:0]        r_out_bounded, n_out_bounded;
    logic                     r_out_err, n_out_err;

    logic [PW:0]         pos_inc;
    logic [PW-1:0]       pos_next;
    logic [TW-1:0]       tap_sum, tap_wrap, tap_fix;
    logic [TW-1:0]       seed_ext;
    logic                seed_ok;
    logic                range_bad;
    logic [DATA_W-1:0]   span_low;
    logic [CNT_W-1:0]    bit_inc, q_inc;
    logic [DATA_W-1:0]   q_shift;
    logic [DATA_W-1:0]   draw;
    logic [DATA_W-1:0]   rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    lxrg_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    lxrg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Position advance and tap index, wrapped by the table depth
    always_comb begin
        pos_inc  = {1'b0, r_pos} + 1'b1;
        pos_next = (pos_inc > LAST_POS) ? '0 : pos_inc[PW-1:0];
        tap_sum  = TW'(pos_next) + TAP_T;
        tap_wrap = (tap_sum > (DEPTH_T - 1'b1)) ? (tap_sum - DEPTH_T) : tap_sum;
        tap_fix  = (tap_wrap >= DEPTH_T) ? '0 : tap_wrap;
        seed_ext = TW'(r_seed_pos);
        seed_ok  = (seed_ext < DEPTH_T);
    end

    // Bounded draw checks and buffer bookkeeping
    always_comb begin
        range_bad = (r_hi < r_lo);
        span_low  = r_hi - r_lo;
        bit_inc   = r_bit_cnt + BIT_STEP;
        q_inc     = r_q_cnt + QUINT_STEP;
        q_shift   = r_q_buf >> QUINT_W;
        draw      = r_a ^ rdata;
    end

    // Table port usage
    always_comb begin
        mem_raddr = (r_state == S_RD_TAP) ? r_tap : pos_next[AW-1:0];
        mem_we    = (r_state == S_XOR) ||
                    ((r_state == S_DECODE) && (r_op == OP_SEED) && seed_ok);
        mem_waddr = (r_state == S_XOR) ? r_pos[AW-1:0] : seed_ext[AW-1:0];
        mem_wdata = (r_state == S_XOR) ? draw : r_seed_word;
    end

    // Divider launch once the drawn word is known
    always_comb begin
        div_req.start    = (r_state == S_XOR) && (r_op == OP_BOUNDED);
        div_req.dividend = draw;
        div_req.divisor  = r_span;
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_tap         = r_tap;
        n_a           = r_a;
        n_span        = r_span;
        n_res_word    = r_res_word;
        n_res_bounded = r_res_bounded;
        n_res_err     = r_res_err;
        n_bit_buf     = r_bit_buf;
        n_bit_cnt     = r_bit_cnt;
        n_q_buf       = r_q_buf;
        n_q_cnt       = r_q_cnt;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_word    = r_out_word;
        n_out_bounded = r_out_bounded;
        n_out_err     = r_out_err;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_word    = '0;
                n_res_bounded = '0;
                n_res_err     = 1'b0;
                n_span        = {1'b0, span_low} + 1'b1;
                n_state       = S_RD_TAP;
                case (r_op)
                    OP_WORD: begin
                    end
                    OP_BOUNDED: begin
                        if (range_bad) begin
                            n_res_err = 1'b1;
                            n_state   = S_EMIT;
                        end
                    end
                    OP_BIT: begin
                        if (bit_inc <= CNT_FULL) begin
                            n_bit_buf  = r_bit_buf >> 1;
                            n_bit_cnt  = bit_inc;
                            n_res_word = DATA_W'(r_bit_buf[1]);
                            n_state    = S_EMIT;
                        end
                    end
                    OP_QUINT: begin
                        if (q_inc <= CNT_FULL) begin
                            n_q_buf    = q_shift;
                            n_q_cnt    = q_inc;
                            n_res_word = DATA_W'(q_shift[QUINT_W-1:0]);
                            n_state    = S_EMIT;
                        end
                    end
                    OP_SETPOS: begin
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                // A draw commits the new position now
                if (n_state == S_RD_TAP) begin
                    n_pos = pos_next;
                    n_tap = tap_fix[AW-1:0];
                end
                if (r_op == OP_SETPOS) begin
                    n_pos = PW'(r_seed_pos);
                end
            end
            S_RD_TAP: begin
                n_a     = rdata;
                n_state = S_XOR;
            end
            S_XOR: begin
                n_res_word = draw;
                n_state    = S_EMIT;
                case (r_op)
                    OP_BOUNDED: begin
                        n_state = S_DIV;
                    end
                    OP_BIT: begin
                        n_bit_buf  = draw;
                        n_bit_cnt  = BIT_STEP;
                        n_res_word = DATA_W'(draw[0]);
                    end
                    OP_QUINT: begin
                        n_q_buf    = draw;
                        n_q_cnt    = QUINT_STEP;
                        n_res_word = DATA_W'(draw[QUINT_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res_bounded = r_lo + div_rsp.remainder;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                // Park the result beat once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_word    = r_res_word;
                    n_out_bounded = r_res_bounded;
                    n_out_err     = r_res_err;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Input beat capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op        <= i_in.op;
            r_lo        <= i_in.lo;
            r_hi        <= i_in.hi;
            r_seed_pos  <= i_in.seed_pos;
            r_seed_word <= i_in.seed_word;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_bit_buf   <= '0;
            r_bit_cnt   <= CNT_FULL;
            r_q_buf     <= '0;
            r_q_cnt     <= CNT_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_bit_buf   <= n_bit_buf;
            r_bit_cnt   <= n_bit_cnt;
            r_q_buf     <= n_q_buf;
            r_q_cnt     <= n_q_cnt;
            r_out_valid <= n_out_valid;
        end
        r_tap         <= n_tap;
        r_a           <= n_a;
        r_span        <= n_span;
        r_res_word    <= n_res_word;
        r_res_bounded <= n_res_bounded;
        r_res_err     <= n_res_err;
        r_out_word    <= n_out_word;
        r_out_bounded <= n_out_bounded;
        r_out_err     <= n_out_err;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.word          = r_out_word;
    assign o_out.bounded_value = r_out_bounded;
    assign o_out.range_error   = r_out_err;

endmodule

// ===== design/lxrg_checker.sv =====
// Port-level checks for the lagged-XOR random generator, bound to the top level.
// Depends on lxrg_pkg and on the top level's channel ports.
module lxrg_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lxrg_pkg::DATA_W-1:0]  i_out_word,
    input logic [lxrg_pkg::DATA_W-1:0]  i_out_bounded,
    input logic                         i_out_err
);
    import lxrg_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
            && $stable(i_out_bounded) && $stable(i_out_err))
        else $error("result beat changed while stalled");

    // A reversed range reports no value
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> (i_out_word == '0) && (i_out_bounded == '0))
        else $error("range error beat carries data");

    // One item at a time: busy the cycle after an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted back to back");

    // Out of reset: idle and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("bad state after reset");

endmodule

bind lagged_xor_random_generator lxrg_checker u_lxrg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_word    (o_out.word),
    .i_out_bounded (o_out.bounded_value),
    .i_out_err     (o_out.range_error)
);

// ===== sim/tb.sv =====
// Testbench for the lagged-XOR random generator: directed, buffer-refill, random and stall tests.
// Predicts every draw in SystemVerilog and checks each result beat against the oldest prediction.
// Depends on lxrg_pkg, lxrg_in_if / lxrg_out_if and lagged_xor_random_generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lxrg_pkg::*;

    // Generator geometry and run limits
    localparam int TBL_DEPTH     = 98;
    localparam int TAP           = 27;
    localparam int BUF_BITS      = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int RX_HOLD_LEN   = 300;
    localparam int TAIL_CYCLES   = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 24;

    // Op codes the package leaves unnamed
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [SPOS_W-1:0]        seed_pos;
        logic [DATA_W-1:0]        seed_word;
    } t_gen_req;

    typedef struct {
        logic [DATA_W-1:0]        word;
        logic signed [DATA_W-1:0] bounded_value;
        logic                     range_error;
    } t_draw_result;

    logic i_clk;
    logic i_rst_n;

    lxrg_in_if  gen_in ();
    lxrg_out_if gen_out ();

    lagged_xor_random_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (gen_in),
        .o_out   (gen_out)
    );

    // Predicted generator state
    logic [DATA_W-1:0] gen_table [TBL_DEPTH];
    logic [SPOS_W-1:0] gen_pos;
    logic [DATA_W-1:0] bit_buf;
    logic [CNT_W-1:0]  bit_cnt;
    logic [DATA_W-1:0] quint_buf;
    logic [CNT_W-1:0]  quint_cnt;

    t_draw_result expected_draws [$];

    int  mismatch_count;
    int  stall_cycles = 0;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  rx_hold_req;
    int  rx_hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One lagged-XOR step: advance position, fold in the tap entry
    function automatic logic [DATA_W-1:0] lag_xor_draw();
        int p;
        int t;
        p = int'(gen_pos) + 1;
        if (p > TBL_DEPTH - 1) p = 0;
        t = p + TAP;
        if (t > TBL_DEPTH - 1) t -= TBL_DEPTH;
        gen_pos = SPOS_W'(p);
        gen_table[p] = gen_table[p] ^ gen_table[t];
        return gen_table[p];
    endfunction

    // Update the predicted state for one accepted request; queue its result if any
    function automatic void forecast_result(t_gen_req req);
        t_draw_result r;
        logic [63:0]  span;
        logic [DATA_W-1:0] w;
        bit           has_result;
        r = '{word: '0, bounded_value: '0, range_error: 1'b0};
        has_result = 1'b1;
        case (req.op)
            OP_WORD: begin
                r.word = lag_xor_draw();
            end
            OP_BOUNDED: begin
                // reversed range: flag only, no draw
                if (req.hi < req.lo) begin
                    r.range_error = 1'b1;
                end else begin
                    span = {32'd0, DATA_W'(req.hi - req.lo)} + 64'd1;
                    w = lag_xor_draw();
                    r.word = w;
                    r.bounded_value = req.lo + DATA_W'({32'd0, w} % span);
                end
            end
            OP_BIT: begin
                bit_buf = bit_buf >> 1;
                bit_cnt = CNT_W'(bit_cnt + 1);
                if (bit_cnt > BUF_BITS) begin
                    bit_buf = lag_xor_draw();
                    bit_cnt = 1;
                end
                r.word = {31'd0, bit_buf[0]};
            end
            OP_QUINT: begin
                quint_buf = quint_buf >> 5;
                quint_cnt = CNT_W'(quint_cnt + 5);
                if (quint_cnt > BUF_BITS) begin
                    quint_buf = lag_xor_draw();
                    quint_cnt = 5;
                end
                r.word = {27'd0, quint_buf[4:0]};
            end
            OP_SEED: begin
                // index past the table is dropped
                if (req.seed_pos < TBL_DEPTH) gen_table[req.seed_pos] = req.seed_word;
                has_result = 1'b0;
            end
            OP_SETPOS: begin
                gen_pos = req.seed_pos;
                has_result = 1'b0;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
        if (has_result) expected_draws.push_back(r);
    endfunction

    function automatic t_gen_req make_req(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] lo,
                                          logic signed [DATA_W-1:0] hi,
                                          logic [SPOS_W-1:0] seed_pos,
                                          logic [DATA_W-1:0] seed_word);
        t_gen_req req;
        req.op        = op;
        req.lo        = lo;
        req.hi        = hi;
        req.seed_pos  = seed_pos;
        req.seed_word = seed_word;
        return req;
    endfunction

    // Random request: mostly draws, with bounded ranges shaped toward the interesting spans
    function automatic t_gen_req rand_request();
        t_gen_req req;
        int pick;
        int shape;
        req = make_req(OP_WORD, $urandom, $urandom, SPOS_W'($urandom_range(0, 127)), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            req.op = OP_WORD;
        end else if (pick < 52) begin
            req.op = OP_BOUNDED;
            shape = $urandom_range(0, 9);
            case (shape)
                0, 1, 2, 3: req.hi = req.lo + $urandom_range(0, 1000);
                4, 5:       req.hi = req.lo + $urandom;
                6: begin
                    req.lo = INT_MIN;
                    req.hi = INT_MAX;
                end
                7:          req.hi = req.lo;
                default:    ;
            endcase
        end else if (pick < 67) begin
            req.op = OP_BIT;
        end else if (pick < 82) begin
            req.op = OP_QUINT;
        end else if (pick < 90) begin
            req.op = OP_SEED;
        end else if (pick < 96) begin
            req.op = OP_SETPOS;
        end else begin
            req.op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
        end
        return req;
    endfunction

    // Offer one request beat and wait for it to be taken
    task automatic send_request(t_gen_req req);
        gen_in.valid     <= 1'b1;
        gen_in.op        <= req.op;
        gen_in.lo        <= req.lo;
        gen_in.hi        <= req.hi;
        gen_in.seed_pos  <= req.seed_pos;
        gen_in.seed_word <= req.seed_word;
        @(posedge i_clk);
        while (!gen_in.ready) @(posedge i_clk);
        forecast_result(req);
    endtask

    // Random sender bubbles
    task automatic sender_gap();
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            gen_in.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        gen_in.valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %08h got %08h", $realtime, what, want, got);
    endtask

    // Fill every table entry before the first draw; extremes placed so the first draw is all ones
    task automatic test_seed_table();
        logic [DATA_W-1:0] w;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            w = $urandom;
            if (i == 1) w = 32'h0000_0000;
            if (i == 28) w = 32'hFFFF_FFFF;
            send_request(make_req(OP_SEED, $urandom, $urandom, SPOS_W'(i), w));
            sender_gap();
        end
    endtask

    task automatic test_directed();
        send_request(make_req(OP_WORD, 0, 0, 0, 0));
        send_request(make_req(OP_BOUNDED, INT_MIN, INT_MAX, 0, 0));
        send_request(make_req(OP_BOUNDED, 5, 5, 0, 0));
        send_request(make_req(OP_BOUNDED, INT_MAX, INT_MIN, 0, 0));
        sender_gap();
        send_request(make_req(OP_BOUNDED, INT_MIN, INT_MIN, 0, 0));
        send_request(make_req(OP_BOUNDED, -10, 10, 0, 0));
        send_request(make_req(OP_BOUNDED, 0, INT_MAX, 0, 0));
        send_request(make_req(OP_BIT, 0, 0, 0, 0));
        send_request(make_req(OP_BIT, 0, 0, 0, 0));
        sender_gap();
        send_request(make_req(OP_QUINT, 0, 0, 0, 0));
        send_request(make_req(OP_QUINT, 0, 0, 0, 0));
        // seed index past the table is ignored
        send_request(make_req(OP_SEED, 0, 0, 7'd98, 32'hDEAD_BEEF));
        send_request(make_req(OP_SEED, 0, 0, 7'd127, 32'hFFFF_FFFF));
        // wrap from the last entry, and from a position past the end
        send_request(make_req(OP_SETPOS, 0, 0, 7'd97, 0));
        send_request(make_req(OP_WORD, 0, 0, 0, 0));
        send_request(make_req(OP_SETPOS, 0, 0, 7'd127, 0));
        send_request(make_req(OP_WORD, INT_MAX, INT_MIN, 7'd127, 32'hFFFF_FFFF));
        sender_gap();
        send_request(make_req(OP_SETPOS, 0, 0, 7'd0, 0));
        send_request(make_req(OP_SPARE_6, 0, 0, 0, 0));
        send_request(make_req(OP_SPARE_7, -1, -1, 7'd127, 32'hFFFF_FFFF));
        send_request(make_req(OP_SEED, 0, 0, 7'd0, 32'h0000_0000));
        // tap wraps past the end of the table
        send_request(make_req(OP_SETPOS, 0, 0, 7'd96, 0));
        send_request(make_req(OP_WORD, 0, 0, 0, 0));
        drain_results();
    endtask

    // Long runs of bit and five-bit draws so each buffer refills several times
    task automatic test_buffer_refill();
        for (int i = 0; i < 70; i++) begin
            send_request(make_req(OP_BIT, $urandom, $urandom, 0, $urandom));
            sender_gap();
        end
        for (int i = 0; i < 20; i++) begin
            send_request(make_req(OP_QUINT, $urandom, $urandom, 0, $urandom));
            sender_gap();
        end
        drain_results();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 900; i++) begin
            send_request(rand_request());
            sender_gap();
        end
        drain_results();
    endtask

    // Stretch with no bubbles on either side
    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < 150; i++) send_request(rand_request());
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_receiver_hold();
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_request(rand_request());
        drain_results();
    endtask

    // Receiver ready, with random bubbles and the long hold-off
    initial begin
        gen_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_left = RX_HOLD_LEN;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                gen_out.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
                gen_out.ready <= 1'b0;
            end else begin
                gen_out.ready <= 1'b1;
            end
        end
    end

    // Compare each result beat against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_draw_result want;
        if (i_rst_n && gen_out.valid && gen_out.ready) begin
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected result word", '0, gen_out.word);
            end else begin
                want = expected_draws.pop_front();
                if (gen_out.word !== want.word)
                    report_mismatch("word", want.word, gen_out.word);
                if (gen_out.bounded_value !== want.bounded_value)
                    report_mismatch("bounded_value", want.bounded_value, gen_out.bounded_value);
                if (gen_out.range_error !== want.range_error)
                    report_mismatch("range_error", 32'(want.range_error), 32'(gen_out.range_error));
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((gen_in.valid && gen_in.ready) || (gen_out.valid && gen_out.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial begin
        i_rst_n          <= 1'b0;
        gen_in.valid     <= 1'b0;
        gen_in.op        <= OP_WORD;
        gen_in.lo        <= '0;
        gen_in.hi        <= '0;
        gen_in.seed_pos  <= '0;
        gen_in.seed_word <= '0;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_req    = 1'b0;
        rx_hold_left   = 0;
        gen_pos        = '0;
        bit_buf        = '0;
        bit_cnt        = 6'd32;
        quint_buf      = '0;
        quint_cnt      = 6'd32;
        for (int i = 0; i < TBL_DEPTH; i++) gen_table[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_seed_table();
        test_directed();
        test_buffer_refill();
        test_random_mix();
        test_no_idle();
        test_receiver_hold();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_draws.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== lagged_xor_random_generator.f =====
design/lxrg_pkg.sv
design/lxrg_if.sv
design/lxrg_divider.sv
design/lxrg_table.sv
design/lagged_xor_random_generator.sv
design/lxrg_checker.sv
sim/tb.sv
